>>> rtl/core/lpe_pkg.sv
// lpe_pkg: shared widths, codes and types for the LSB payload extractor.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package lpe_pkg;

  // Field and register widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BITS_W    = 3;
  localparam int unsigned COUNT_W   = 27;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned HDR_W     = 3;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned HDR_BYTES = 4;

  // Largest image the block is built for, in channel bytes
  localparam int unsigned MAX_CHANNELS_DEFAULT = 67108864;

  // Low-bit chunk size limits
  localparam logic [BITS_W-1:0] BITS_MIN   = 3'd1;
  localparam logic [BITS_W-1:0] BITS_MAX   = 3'd4;
  localparam logic [BITS_W-1:0] BITS_RESET = 3'd1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_BITS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LEN_ERR   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

  // Extraction phase of the current image
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [BITS_W-1:0]  bits;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  // One result item from the extraction core
  typedef struct packed {
    logic                valid;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

>>> rtl/core/lsb_payload_extract_top.sv
// lsb_payload_extract_top: extracts a length-prefixed payload from image LSBs.
// Depends on lpe_pkg, lpe_cfg, lpe_core and lpe_out_stage.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_write              cfg_index, cfg_data
//   in        in         in_valid / in_stall    channel_value, start_of_image
//   out       out        out_valid / out_stall  payload_byte, last_byte, status
//
// One channel byte is taken every cycle unless in_stall is high; its result, if any,
// appears on the output register the cycle after acceptance.
// The whole update for an item is one pass of logic into the state registers.
// in_stall rises only when the output register is full and out_stall is high.
// Synchronous reset sets the chunk size to 1, channel_count to 0 and
// returns extraction to the header phase.
`timescale 1ns / 1ps

module lsb_payload_extract_top #(
  parameter int unsigned MAX_CHANNELS = lpe_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lpe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpe_pkg::COUNT_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lpe_pkg::BYTE_W-1:0]      channel_value,
  input  logic                            start_of_image,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpe_pkg::BYTE_W-1:0]      payload_byte,
  output logic                            last_byte,
  output logic [lpe_pkg::STATUS_W-1:0]    status
);

  lpe_pkg::cfg_t    cfg;
  lpe_pkg::result_t result;
  logic             in_accept;

  // Item taken when valid and not held
  assign in_accept = in_valid & ~in_stall;

  lpe_cfg #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpe_core #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (in_accept),
    .channel_value  (channel_value),
    .start_of_image (start_of_image),
    .result         (result)
  );

  lpe_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .result       (result),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .status       (status)
  );

endmodule

>>> rtl/core/lpe_cfg.sv
// lpe_cfg: configuration registers and their clamping to legal ranges.
// Depends on lpe_pkg.
`timescale 1ns / 1ps

module lpe_cfg #(
  parameter int unsigned MAX_CHANNELS = lpe_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lpe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpe_pkg::COUNT_W-1:0]     cfg_data,
  output lpe_pkg::cfg_t                   cfg
);

  logic [lpe_pkg::BITS_W-1:0]  chunk_bits;
  logic [lpe_pkg::COUNT_W-1:0] channel_count;

  // Write registers by index
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bits    <= lpe_pkg::BITS_RESET;
      channel_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lpe_pkg::CFG_CHUNK_BITS: begin
          chunk_bits <= cfg_data[lpe_pkg::BITS_W-1:0];
        end
        lpe_pkg::CFG_CHANNEL_COUNT: begin
          channel_count <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp chunk size to 1..4 and channel count to the build limit
  always_comb begin
    if (chunk_bits < lpe_pkg::BITS_MIN) begin
      cfg.bits = lpe_pkg::BITS_MIN;
    end else if (chunk_bits > lpe_pkg::BITS_MAX) begin
      cfg.bits = lpe_pkg::BITS_MAX;
    end else begin
      cfg.bits = chunk_bits;
    end
    if (64'(channel_count) > 64'(MAX_CHANNELS)) begin
      cfg.count = lpe_pkg::COUNT_W'(MAX_CHANNELS);
    end else begin
      cfg.count = channel_count;
    end
  end

endmodule

>>> rtl/core/lpe_core.sv
// lpe_core: per-image extraction state and the combinational update for one item.
// Depends on lpe_pkg; fed by lpe_cfg, drains into lpe_out_stage.
`timescale 1ns / 1ps

module lpe_core #(
  parameter int unsigned MAX_CHANNELS = lpe_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lpe_pkg::cfg_t              cfg,
  input  logic                       accept,
  input  logic [lpe_pkg::BYTE_W-1:0] channel_value,
  input  logic                       start_of_image,
  output lpe_pkg::result_t           result
);

  localparam int unsigned IDX_BITS = $clog2(64'(MAX_CHANNELS) + 64'd1);
  localparam int unsigned CNT_W    = (IDX_BITS < lpe_pkg::COUNT_W) ? IDX_BITS
                                                                   : lpe_pkg::COUNT_W;
  localparam int unsigned PROD_W   = CNT_W + 2;

  // Image state
  logic [lpe_pkg::BYTE_W-1:0] acc;
  logic [lpe_pkg::POS_W-1:0]  pos;
  logic [CNT_W-1:0]           idx;
  logic [lpe_pkg::HDR_W-1:0]  hdr;
  logic [lpe_pkg::LEN_W-1:0]  plen;
  logic [lpe_pkg::LEN_W-1:0]  remaining;
  lpe_pkg::phase_t            phase;

  logic [lpe_pkg::BYTE_W-1:0] acc_next;
  logic [lpe_pkg::POS_W-1:0]  pos_next;
  logic [CNT_W-1:0]           idx_next;
  logic [lpe_pkg::HDR_W-1:0]  hdr_next;
  logic [lpe_pkg::LEN_W-1:0]  plen_next;
  logic [lpe_pkg::LEN_W-1:0]  remaining_next;
  lpe_pkg::phase_t            phase_next;

  // State as seen by this item (start of image clears it first)
  logic [lpe_pkg::BYTE_W-1:0] acc_s;
  logic [lpe_pkg::POS_W-1:0]  pos_s;
  logic [CNT_W-1:0]           idx_s;
  logic [lpe_pkg::HDR_W-1:0]  hdr_s;
  logic [lpe_pkg::LEN_W-1:0]  plen_s;
  logic [lpe_pkg::LEN_W-1:0]  remaining_s;
  lpe_pkg::phase_t            phase_s;

  logic [CNT_W-1:0]           count_c;
  logic [lpe_pkg::BYTE_W-1:0] chunk_mask;
  logic [2*lpe_pkg::BYTE_W-1:0] chunk_wide;
  logic [lpe_pkg::BYTE_W-1:0] acc_merge;
  logic [lpe_pkg::POS_W:0]    pos_sum;
  logic                       complete;
  logic [CNT_W-1:0]           idx_inc;
  logic                       ended;
  logic                       skip;
  logic [lpe_pkg::HDR_W-1:0]  hdr_inc;
  logic                       header_done;
  logic [lpe_pkg::LEN_W-1:0]  plen_merge;
  logic [lpe_pkg::LEN_W-1:0]  remaining_dec;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-1:0]          cap_full;
  logic [PROD_W-1:0]          cap;
  logic                       len_bad;

  // Apply restart ahead of the update
  always_comb begin
    if (start_of_image) begin
      acc_s       = '0;
      pos_s       = '0;
      idx_s       = '0;
      hdr_s       = '0;
      plen_s      = '0;
      remaining_s = '0;
      phase_s     = lpe_pkg::PH_HEADER;
    end else begin
      acc_s       = acc;
      pos_s       = pos;
      idx_s       = idx;
      hdr_s       = hdr;
      plen_s      = plen;
      remaining_s = remaining;
      phase_s     = phase;
    end
  end

  // Chunk merge, position and channel counting
  always_comb begin
    count_c       = cfg.count[CNT_W-1:0];
    chunk_mask    = lpe_pkg::BYTE_W'((9'd1 << cfg.bits) - 9'd1);
    chunk_wide    = {8'd0, channel_value & chunk_mask} << pos_s;
    acc_merge     = acc_s | chunk_wide[lpe_pkg::BYTE_W-1:0];
    pos_sum       = {1'b0, pos_s} + {1'b0, cfg.bits};
    complete      = pos_sum[lpe_pkg::POS_W];
    idx_inc       = idx_s + CNT_W'(1);
    ended         = idx_inc >= count_c;
    skip          = (phase_s == lpe_pkg::PH_DONE) || (idx_s >= count_c);
    hdr_inc       = hdr_s + 3'd1;
    header_done   = complete && (hdr_inc == lpe_pkg::HDR_W'(lpe_pkg::HDR_BYTES));
    plen_merge    = plen_s | (lpe_pkg::LEN_W'(acc_merge) << {hdr_s[1:0], 3'b000});
    remaining_dec = remaining_s - 32'd1;
  end

  // Capacity in bytes after the length header, saturating at zero
  always_comb begin
    case (cfg.bits)
      3'd1:    prod = PROD_W'(count_c);
      3'd2:    prod = PROD_W'(count_c) << 1;
      3'd3:    prod = PROD_W'(count_c) + (PROD_W'(count_c) << 1);
      default: prod = PROD_W'(count_c) << 2;
    endcase
    cap_full = prod >> 3;
    cap      = (cap_full > PROD_W'(lpe_pkg::HDR_BYTES))
               ? cap_full - PROD_W'(lpe_pkg::HDR_BYTES) : '0;
    len_bad  = (plen_merge == '0) || (plen_merge > lpe_pkg::LEN_W'(cap));
  end

  // Next state
  always_comb begin
    acc_next       = acc_s;
    pos_next       = pos_s;
    idx_next       = idx_s;
    hdr_next       = hdr_s;
    plen_next      = plen_s;
    remaining_next = remaining_s;
    phase_next     = phase_s;
    if (!skip) begin
      acc_next = acc_merge;
      pos_next = complete ? '0 : pos_sum[lpe_pkg::POS_W-1:0];
      idx_next = idx_inc;
      case (phase_s)
        lpe_pkg::PH_HEADER: begin
          if (complete) begin
            plen_next = plen_merge;
            hdr_next  = hdr_inc;
            acc_next  = '0;
          end
          if (header_done) begin
            if (len_bad) begin
              phase_next = lpe_pkg::PH_DONE;
            end else begin
              remaining_next = plen_merge;
              phase_next     = ended ? lpe_pkg::PH_DONE : lpe_pkg::PH_PAYLOAD;
            end
          end else if (ended) begin
            phase_next = lpe_pkg::PH_DONE;
          end
        end
        lpe_pkg::PH_PAYLOAD: begin
          if (complete) begin
            acc_next       = '0;
            remaining_next = remaining_dec;
            if ((remaining_dec == '0) || ended) begin
              phase_next = lpe_pkg::PH_DONE;
            end
          end else if (ended) begin
            phase_next = lpe_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for this item
  always_comb begin
    result.valid  = 1'b0;
    result.data   = '0;
    result.last   = 1'b0;
    result.status = lpe_pkg::STATUS_OK;
    if (!skip) begin
      case (phase_s)
        lpe_pkg::PH_HEADER: begin
          if (header_done) begin
            if (len_bad) begin
              result.valid  = 1'b1;
              result.last   = 1'b1;
              result.status = lpe_pkg::STATUS_LEN_ERR;
            end else if (ended) begin
              result.valid  = 1'b1;
              result.last   = 1'b1;
              result.status = lpe_pkg::STATUS_TRUNCATED;
            end
          end else if (ended) begin
            result.valid  = 1'b1;
            result.last   = 1'b1;
            result.status = lpe_pkg::STATUS_LEN_ERR;
          end
        end
        lpe_pkg::PH_PAYLOAD: begin
          if (complete) begin
            result.valid = 1'b1;
            result.data  = acc_merge;
            if (remaining_dec == '0) begin
              result.last = 1'b1;
            end else if (ended) begin
              result.last   = 1'b1;
              result.status = lpe_pkg::STATUS_TRUNCATED;
            end
          end else if (ended) begin
            result.valid  = 1'b1;
            result.data   = acc_merge;
            result.last   = 1'b1;
            result.status = lpe_pkg::STATUS_TRUNCATED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Commit state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pos       <= '0;
      idx       <= '0;
      hdr       <= '0;
      plen      <= '0;
      remaining <= '0;
      phase     <= lpe_pkg::PH_HEADER;
    end else if (accept) begin
      acc       <= acc_next;
      pos       <= pos_next;
      idx       <= idx_next;
      hdr       <= hdr_next;
      plen      <= plen_next;
      remaining <= remaining_next;
      phase     <= phase_next;
    end
  end

  // A payload in progress always has bytes left to give
  assert property (@(posedge clk) disable iff (rst)
    phase == lpe_pkg::PH_PAYLOAD |-> remaining != '0)
    else $error("payload phase with no bytes remaining");

  // The payload phase is reached only after the full length header
  assert property (@(posedge clk) disable iff (rst)
    phase == lpe_pkg::PH_PAYLOAD |-> hdr == lpe_pkg::HDR_W'(lpe_pkg::HDR_BYTES))
    else $error("payload phase before header complete");

  // Only the final result of an image may carry a non-ok status
  assert property (@(posedge clk) disable iff (rst)
    accept && result.valid && !result.last |-> result.status == lpe_pkg::STATUS_OK)
    else $error("non-final result with error status");

  // The final result closes the image
  assert property (@(posedge clk) disable iff (rst)
    accept && result.valid && result.last |=> phase == lpe_pkg::PH_DONE)
    else $error("image not closed after final result");

endmodule

>>> rtl/core/lpe_out_stage.sv
// lpe_out_stage: result register that parts the core from the output channel.
// Depends on lpe_pkg; loaded from lpe_core.
`timescale 1ns / 1ps

module lpe_out_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  lpe_pkg::result_t             result,
  input  logic                         out_stall,
  output logic                         in_stall,
  output logic                         out_valid,
  output logic [lpe_pkg::BYTE_W-1:0]   payload_byte,
  output logic                         last_byte,
  output logic [lpe_pkg::STATUS_W-1:0] status
);

  logic load;

  // Hold the input side only while a result waits and the sink stalls
  assign in_stall = out_valid & out_stall;
  assign load     = accept & result.valid;

  // Valid flag: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (load) begin
      payload_byte <= result.data;
      last_byte    <= result.last;
      status       <= result.status;
    end
  end

endmodule

>>> tb/lsb_extract_checker.sv
// lsb_extract_checker: watches the config, input and output channels of the
// payload extractor, predicts every extracted byte and compares it on arrival.
// Depends on lpe_pkg for widths, status codes, register indexes and phases.
`timescale 1ns / 1ps

module lsb_extract_checker #(
  parameter int unsigned MAX_CHANNELS = lpe_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lpe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpe_pkg::COUNT_W-1:0]     cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [lpe_pkg::BYTE_W-1:0]      channel_value,
  input  logic                            start_of_image,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [lpe_pkg::BYTE_W-1:0]      payload_byte,
  input  logic                            last_byte,
  input  logic [lpe_pkg::STATUS_W-1:0]    status,
  output int                              pending,
  output int                              fail_count
);

  typedef struct packed {
    logic [lpe_pkg::BYTE_W-1:0]   data;
    logic                         last;
    logic [lpe_pkg::STATUS_W-1:0] status;
  } extracted_t;

  extracted_t expected_bytes[$];

  // Register copies
  logic [lpe_pkg::BITS_W-1:0]  bits_reg;
  logic [lpe_pkg::COUNT_W-1:0] count_reg;

  // Per-image extraction state
  logic [lpe_pkg::BYTE_W-1:0]  acc;
  logic [lpe_pkg::POS_W-1:0]   chunk_pos;
  logic [lpe_pkg::COUNT_W-1:0] chan_idx;
  logic [lpe_pkg::HDR_W-1:0]   hdr_count;
  logic [lpe_pkg::LEN_W-1:0]   hdr_length;
  logic [lpe_pkg::LEN_W-1:0]   bytes_left;
  lpe_pkg::phase_t             img_phase;

  function automatic void clear_image();
    acc        = '0;
    chunk_pos  = '0;
    chan_idx   = '0;
    hdr_count  = '0;
    hdr_length = '0;
    bytes_left = '0;
    img_phase  = lpe_pkg::PH_HEADER;
  endfunction

  // Queue one expected byte and close the image when it is the last one
  function automatic void expect_byte(input logic [lpe_pkg::BYTE_W-1:0] data,
                                      input logic last,
                                      input logic [lpe_pkg::STATUS_W-1:0] code);
    extracted_t item;
    item.data   = data;
    item.last   = last;
    item.status = code;
    expected_bytes.push_back(item);
    if (last) img_phase = lpe_pkg::PH_DONE;
  endfunction

  // Advance the extraction state by one accepted channel byte
  function automatic void predict_channel(input logic [lpe_pkg::BYTE_W-1:0] value,
                                          input logic soi);
    int unsigned                b;
    int unsigned                cnt;
    int unsigned                next_pos;
    longint unsigned            cap;
    logic [lpe_pkg::BYTE_W-1:0] data;
    logic                       complete;
    logic                       ended;
    if (soi) clear_image();
    b = bits_reg;
    if (b < lpe_pkg::BITS_MIN) b = lpe_pkg::BITS_MIN;
    if (b > lpe_pkg::BITS_MAX) b = lpe_pkg::BITS_MAX;
    cnt = count_reg;
    if (cnt > MAX_CHANNELS) cnt = MAX_CHANNELS;
    if (img_phase == lpe_pkg::PH_DONE || chan_idx >= cnt) return;

    // pack the low chunk; bits past bit 7 fall off
    acc = acc | ((value & lpe_pkg::BYTE_W'((1 << b) - 1)) << chunk_pos);
    next_pos = chunk_pos + b;
    complete = (next_pos >= lpe_pkg::BYTE_W);
    chunk_pos = complete ? '0 : lpe_pkg::POS_W'(next_pos);
    chan_idx = chan_idx + 1'b1;
    ended = (chan_idx >= cnt);

    if (img_phase == lpe_pkg::PH_HEADER) begin
      if (complete) begin
        hdr_length = hdr_length | (lpe_pkg::LEN_W'(acc) << (8 * hdr_count[1:0]));
        hdr_count = hdr_count + 1'b1;
        acc = '0;
        if (hdr_count >= lpe_pkg::HDR_BYTES) begin
          cap = cnt;
          cap = (cap * b) / lpe_pkg::BYTE_W;
          cap = (cap > lpe_pkg::HDR_BYTES) ? cap - lpe_pkg::HDR_BYTES : 0;
          if (hdr_length == '0 || hdr_length > cap) begin
            expect_byte('0, 1'b1, lpe_pkg::STATUS_LEN_ERR);
            return;
          end
          img_phase = lpe_pkg::PH_PAYLOAD;
          bytes_left = hdr_length;
          if (ended) expect_byte('0, 1'b1, lpe_pkg::STATUS_TRUNCATED);
          return;
        end
      end
      if (ended) expect_byte('0, 1'b1, lpe_pkg::STATUS_LEN_ERR);
      return;
    end

    if (complete) begin
      data = acc;
      acc = '0;
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0)
        expect_byte(data, 1'b1, lpe_pkg::STATUS_OK);
      else if (ended)
        expect_byte(data, 1'b1, lpe_pkg::STATUS_TRUNCATED);
      else
        expect_byte(data, 1'b0, lpe_pkg::STATUS_OK);
    end else if (ended) begin
      expect_byte(acc, 1'b1, lpe_pkg::STATUS_TRUNCATED);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare outputs first, then predict from inputs, then apply config writes
  always @(posedge clk) begin : watch
    extracted_t want;
    if (rst) begin
      bits_reg  = lpe_pkg::BITS_RESET;
      count_reg = '0;
      clear_image();
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                   $time, payload_byte, last_byte, status);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("payload_byte", want.data, payload_byte);
          check_field("last_byte", want.last, last_byte);
          check_field("status", want.status, status);
        end
      end
      if (in_valid && !in_stall) predict_channel(channel_value, start_of_image);
      if (cfg_write) begin
        case (cfg_index)
          lpe_pkg::CFG_CHUNK_BITS:    bits_reg = cfg_data[lpe_pkg::BITS_W-1:0];
          lpe_pkg::CFG_CHANNEL_COUNT: count_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_bytes.size();
  end

endmodule

>>> tb/tb_lsb_payload_extract_top.sv
// tb_lsb_payload_extract_top: drives stego channel bytes and register writes
// into lsb_payload_extract_top; lsb_extract_checker predicts and compares.
// Depends on lpe_pkg, the RTL under rtl/core and tb/lsb_extract_checker.sv.
`timescale 1ns / 1ps

module tb_lsb_payload_extract_top;

  localparam int unsigned RUN_ITEMS    = 450;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IMAGE_SPAN   = 120;
  localparam longint unsigned LIMIT_NS = 3_000_000;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [lpe_pkg::CFG_INDEX_W-1:0] cfg_index = lpe_pkg::CFG_CHUNK_BITS;
  logic [lpe_pkg::COUNT_W-1:0]     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [lpe_pkg::BYTE_W-1:0]      channel_value = '0;
  logic                            start_of_image = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [lpe_pkg::BYTE_W-1:0]      payload_byte;
  logic                            last_byte;
  logic [lpe_pkg::STATUS_W-1:0]    status;

  int pending;
  int fail_count;

  int unsigned                 send_idle_pct = 0;
  int unsigned                 stall_pct = 0;
  int unsigned                 items_sent = 0;
  logic [lpe_pkg::BITS_W-1:0]  cur_bits = lpe_pkg::BITS_RESET;
  logic [lpe_pkg::COUNT_W-1:0] cur_count = '0;

  lsb_payload_extract_top u_top (.*);

  lsb_extract_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: stall at random at the current rate
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int unsigned eff_bits();
    if (cur_bits < lpe_pkg::BITS_MIN) return lpe_pkg::BITS_MIN;
    if (cur_bits > lpe_pkg::BITS_MAX) return lpe_pkg::BITS_MAX;
    return cur_bits;
  endfunction

  function automatic int unsigned eff_count();
    return (cur_count > lpe_pkg::MAX_CHANNELS_DEFAULT) ? lpe_pkg::MAX_CHANNELS_DEFAULT
                                                       : cur_count;
  endfunction

  // Drop valid and hold until every expected byte is back and the block is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [lpe_pkg::BITS_W-1:0] bits,
                              input logic [lpe_pkg::COUNT_W-1:0] count);
    cfg_write <= 1'b1;
    cfg_index <= lpe_pkg::CFG_CHUNK_BITS;
    cfg_data  <= {(lpe_pkg::COUNT_W - lpe_pkg::BITS_W)'($urandom), bits};
    @(posedge clk);
    cfg_index <= lpe_pkg::CFG_CHANNEL_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_bits  = bits;
    cur_count = count;
  endtask

  // Offer one channel byte, idling first at the sender rate, and hold it until taken
  task automatic send_channel(input logic [lpe_pkg::BYTE_W-1:0] value, input logic soi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    channel_value  <= value;
    start_of_image <= soi;
    do @(posedge clk); while (in_stall);
  endtask

  // Encode a length header and random payload into the low bits of n_send channels
  task automatic send_image(input logic [lpe_pkg::LEN_W-1:0] length,
                            input int unsigned n_send, input int unsigned noise_pct);
    int unsigned                eb;
    int unsigned                per_byte;
    int unsigned                pos;
    int unsigned                byte_idx;
    int unsigned                k;
    logic [lpe_pkg::BYTE_W-1:0] cur_byte;
    logic [lpe_pkg::BYTE_W-1:0] lane;
    logic [lpe_pkg::BYTE_W-1:0] value;
    logic                       soi;
    eb = eff_bits();
    per_byte = (lpe_pkg::BYTE_W + eb - 1) / eb;
    cur_byte = '0;
    for (k = 0; k < n_send; k++) begin
      byte_idx = k / per_byte;
      pos = (k % per_byte) * eb;
      if (pos == 0)
        cur_byte = (byte_idx < lpe_pkg::HDR_BYTES)
                   ? lpe_pkg::BYTE_W'(length >> (8 * byte_idx))
                   : lpe_pkg::BYTE_W'($urandom);
      // only the chunk bits that land inside the byte carry data
      lane = lpe_pkg::BYTE_W'((1 << eb) - 1) & (8'hFF >> pos);
      value = lpe_pkg::BYTE_W'($urandom);
      value = (value & ~lane) | ((cur_byte >> pos) & lane);
      if ($urandom_range(99) < noise_pct) value = lpe_pkg::BYTE_W'($urandom);
      soi = (k == 0) ? ($urandom_range(99) >= noise_pct) : ($urandom_range(199) < noise_pct);
      send_channel(value, soi);
      items_sent++;
    end
  endtask

  initial begin : stimulus
    int unsigned                 r;
    int unsigned                 eb;
    int unsigned                 per_byte;
    int unsigned                 cnt;
    int unsigned                 fit;
    int unsigned                 n_send;
    int unsigned                 noise;
    int unsigned                 phase_idx;
    longint unsigned             cap;
    logic [lpe_pkg::LEN_W-1:0]   length;
    logic [lpe_pkg::BITS_W-1:0]  bits;
    logic [lpe_pkg::COUNT_W-1:0] count;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: channel count still zero after reset, so these are dropped
    send_image(32'd1, 2, 0);
    wait_idle();
    // image of one channel ends inside the header
    write_config(3'd1, 27'd1);
    send_image(32'd1, 1, 0);
    wait_idle();
    // capacity says one byte fits, but the image ends mid byte
    write_config(3'd3, 27'd14);
    send_image(32'd1, 14, 0);
    wait_idle();
    // out-of-range bits act as 4, oversized count is clamped, zero length
    write_config(3'd7, '1);
    send_image(32'd0, 8, 0);

    // Random phases: new settings, then a few images under one idling mode
    phase_idx = 0;
    while (items_sent < RUN_ITEMS) begin
      wait_idle();
      bits = ($urandom_range(99) < 15) ? lpe_pkg::BITS_W'($urandom_range(0, 7))
                                       : lpe_pkg::BITS_W'($urandom_range(1, 4));
      r = $urandom_range(99);
      if (r < 4)       count = '0;
      else if (r < 7)  count = 27'd1;
      else if (r < 10) count = lpe_pkg::COUNT_W'(lpe_pkg::MAX_CHANNELS_DEFAULT);
      else if (r < 13) count = '1;
      else             count = lpe_pkg::COUNT_W'($urandom_range(8, IMAGE_SPAN));
      write_config(bits, count);

      case (phase_idx % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase

      repeat ($urandom_range(2, 4)) begin
        if (items_sent >= RUN_ITEMS) break;
        eb = eff_bits();
        per_byte = (lpe_pkg::BYTE_W + eb - 1) / eb;
        cnt = eff_count();
        cap = cnt;
        cap = (cap * eb) / lpe_pkg::BYTE_W;
        cap = (cap > lpe_pkg::HDR_BYTES) ? cap - lpe_pkg::HDR_BYTES : 0;
        fit = ((cnt < IMAGE_SPAN) ? cnt : IMAGE_SPAN) / per_byte;
        fit = (fit > lpe_pkg::HDR_BYTES) ? fit - lpe_pkg::HDR_BYTES : 0;
        if (fit > cap) fit = cap;
        if (fit == 0) fit = 1;

        // pick a length: mostly one that fits, plus the capacity edges and junk
        r = $urandom_range(99);
        if (r < 60)      length = $urandom_range(1, fit);
        else if (r < 72) length = lpe_pkg::LEN_W'(cap);
        else if (r < 80) length = lpe_pkg::LEN_W'(cap + 1);
        else if (r < 86) length = '0;
        else             length = $urandom;

        // send the whole image, or cut it short, or run past its end
        if (cnt == 0)
          n_send = $urandom_range(1, 3);
        else if (cnt <= IMAGE_SPAN)
          n_send = cnt;
        else
          n_send = (lpe_pkg::HDR_BYTES + ((length < 20) ? length : 20)) * per_byte
                   + $urandom_range(0, 3);
        r = $urandom_range(99);
        if (r < 12)      n_send = n_send + $urandom_range(1, 4);
        else if (r < 22) n_send = $urandom_range(1, n_send);

        // keep the run near its item budget
        if (n_send > RUN_ITEMS - items_sent) n_send = RUN_ITEMS - items_sent;

        noise = ($urandom_range(99) < 80) ? 0 : 5;
        send_image(length, n_send, noise);
      end
      phase_idx++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("lsb_payload_extract_top regression: pass");
    end else begin
      $display("lsb_payload_extract_top regression: fail");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("lsb_payload_extract_top regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lpe_pkg.sv
rtl/core/lpe_cfg.sv
rtl/core/lpe_core.sv
rtl/core/lpe_out_stage.sv
rtl/core/lsb_payload_extract_top.sv
tb/lsb_extract_checker.sv
tb/tb_lsb_payload_extract_top.sv
